FILE: src/hrct_pkg.sv
// Shared constants, types and helper functions for the HTTP request completeness tracker.
package hrct_pkg;

  // Default widths of the length and position counters
  localparam int LENGTH_BITS_DEF   = 24;
  localparam int POSITION_BITS_DEF = 16;

  // Character codes
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Length of the "content-length:" field name
  localparam logic [3:0] NAME_LEN = 4'd15;

  // Per-line parser phase
  typedef enum logic [2:0] {
    PH_LINE_START = 3'd0,
    PH_MATCH      = 3'd1,
    PH_SPACES     = 3'd2,
    PH_DIGITS     = 3'd3,
    PH_REST       = 3'd4
  } phase_t;

  // ASCII upper case to lower case
  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // Lower-case field name, one character per index
  function automatic logic [7:0] name_char(input logic [3:0] k);
    logic [7:0] r;
    case (k)
      4'd0:    r = 8'h63; // c
      4'd1:    r = 8'h6F; // o
      4'd2:    r = 8'h6E; // n
      4'd3:    r = 8'h74; // t
      4'd4:    r = 8'h65; // e
      4'd5:    r = 8'h6E; // n
      4'd6:    r = 8'h74; // t
      4'd7:    r = 8'h2D; // -
      4'd8:    r = 8'h6C; // l
      4'd9:    r = 8'h65; // e
      4'd10:   r = 8'h6E; // n
      4'd11:   r = 8'h67; // g
      4'd12:   r = 8'h74; // t
      4'd13:   r = 8'h68; // h
      4'd14:   r = 8'h3A; // :
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

FILE: src/hrct_track.sv
// Per-byte tracking state and combinational next-state / result logic.
module hrct_track #(
  parameter int LENGTH_BITS   = hrct_pkg::LENGTH_BITS_DEF,
  parameter int POSITION_BITS = hrct_pkg::POSITION_BITS_DEF,
  parameter int RES_W         = ((2 * LENGTH_BITS + POSITION_BITS + 3 + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             take,        // a word is accepted this cycle
  input  logic [7:0]       data_byte,
  input  logic             first_byte,
  output logic [RES_W-1:0] res_word     // result for the word taken this cycle
);

  localparam int MUL_W = LENGTH_BITS + 4;
  localparam int PAD_W = RES_W - (2 * LENGTH_BITS + POSITION_BITS + 3);

  // State registers
  logic [23:0]              recent_r, recent_nxt;
  hrct_pkg::phase_t         phase_r, phase_nxt;
  logic [3:0]               idx_r, idx_nxt;
  logic                     found_r, found_nxt;
  logic [LENGTH_BITS-1:0]   len_r, len_nxt;
  logic                     hdr_r, hdr_nxt;
  logic [POSITION_BITS-1:0] hcnt_r, hcnt_nxt;
  logic [LENGTH_BITS-1:0]   bcnt_r, bcnt_nxt;
  logic                     ovf_r, ovf_nxt;

  // Base state: cleared when a new request starts
  logic [23:0]              recent_b;
  hrct_pkg::phase_t         phase_b;
  logic [3:0]               idx_b;
  logic                     found_b;
  logic [LENGTH_BITS-1:0]   len_b;
  logic                     hdr_b;
  logic [POSITION_BITS-1:0] hcnt_b;
  logic [LENGTH_BITS-1:0]   bcnt_b;
  logic                     ovf_b;

  logic [7:0]       c_fold;
  logic [7:0]       prev;
  logic [MUL_W-1:0] len_mul;
  logic             len_sat;
  logic             complete;

  always_comb begin
    recent_b = first_byte ? 24'd0 : recent_r;
    phase_b  = first_byte ? hrct_pkg::PH_LINE_START : phase_r;
    idx_b    = first_byte ? 4'd0 : idx_r;
    found_b  = first_byte ? 1'b0 : found_r;
    len_b    = first_byte ? '0 : len_r;
    hdr_b    = first_byte ? 1'b0 : hdr_r;
    hcnt_b   = first_byte ? '0 : hcnt_r;
    bcnt_b   = first_byte ? '0 : bcnt_r;
    ovf_b    = first_byte ? 1'b0 : ovf_r;
  end

  // Length times ten plus the new digit, with saturation detect
  always_comb begin
    len_mul = ({{4{1'b0}}, len_b} << 3) + ({{4{1'b0}}, len_b} << 1)
            + {{(MUL_W - 8){1'b0}}, data_byte - hrct_pkg::CH_ZERO};
    len_sat = |len_mul[MUL_W-1:LENGTH_BITS];
  end

  assign c_fold = hrct_pkg::fold_case(data_byte);
  assign prev   = recent_b[7:0];

  // Next state
  always_comb begin
    recent_nxt = {recent_b[15:0], data_byte};
    phase_nxt  = phase_b;
    idx_nxt    = idx_b;
    found_nxt  = found_b;
    len_nxt    = len_b;
    hdr_nxt    = hdr_b;
    hcnt_nxt   = hcnt_b;
    bcnt_nxt   = bcnt_b;
    ovf_nxt    = ovf_b;

    if (hdr_b) begin
      // Body byte
      if (bcnt_b != '1) begin
        bcnt_nxt = bcnt_b + 1'b1;
      end else begin
        ovf_nxt = 1'b1;
      end
    end else begin
      if (hcnt_b != '1) begin
        hcnt_nxt = hcnt_b + 1'b1;
      end else begin
        ovf_nxt = 1'b1;
      end

      // Header line parsing
      if (phase_b == hrct_pkg::PH_LINE_START) begin
        if (data_byte != hrct_pkg::CH_CR && data_byte != hrct_pkg::CH_LF) begin
          if (found_b) begin
            phase_nxt = hrct_pkg::PH_REST;
          end else if (c_fold == hrct_pkg::name_char(4'd0)) begin
            idx_nxt   = 4'd1;
            phase_nxt = hrct_pkg::PH_MATCH;
          end else begin
            phase_nxt = hrct_pkg::PH_REST;
          end
        end
      end else if (data_byte == hrct_pkg::CH_LF && prev == hrct_pkg::CH_CR) begin
        phase_nxt = hrct_pkg::PH_LINE_START;
        idx_nxt   = 4'd0;
      end else begin
        case (phase_b)
          hrct_pkg::PH_MATCH: begin
            if (idx_b < hrct_pkg::NAME_LEN && c_fold == hrct_pkg::name_char(idx_b)) begin
              idx_nxt = idx_b + 4'd1;
              if (idx_b + 4'd1 >= hrct_pkg::NAME_LEN) begin
                found_nxt = 1'b1;
                phase_nxt = hrct_pkg::PH_SPACES;
              end
            end else begin
              phase_nxt = hrct_pkg::PH_REST;
            end
          end
          hrct_pkg::PH_SPACES: begin
            if (data_byte != hrct_pkg::CH_SPACE) begin
              if (hrct_pkg::is_digit(data_byte)) begin
                phase_nxt = hrct_pkg::PH_DIGITS;
                len_nxt   = len_sat ? '1 : len_mul[LENGTH_BITS-1:0];
                if (len_sat) ovf_nxt = 1'b1;
              end else begin
                phase_nxt = hrct_pkg::PH_REST;
              end
            end
          end
          hrct_pkg::PH_DIGITS: begin
            if (hrct_pkg::is_digit(data_byte)) begin
              len_nxt = len_sat ? '1 : len_mul[LENGTH_BITS-1:0];
              if (len_sat) ovf_nxt = 1'b1;
            end else begin
              phase_nxt = hrct_pkg::PH_REST;
            end
          end
          default: phase_nxt = hrct_pkg::PH_REST;
        endcase
      end

      // Blank line ends the header
      if (recent_b == {hrct_pkg::CH_CR, hrct_pkg::CH_LF, hrct_pkg::CH_CR} &&
          data_byte == hrct_pkg::CH_LF) begin
        hdr_nxt = 1'b1;
      end
    end
  end

  // Result word, header_done in bit 0
  assign complete = hdr_nxt && ((len_nxt == '0) || (bcnt_nxt >= len_nxt));
  assign res_word = {{PAD_W{1'b0}}, ovf_nxt, bcnt_nxt, hcnt_nxt, len_nxt, complete, hdr_nxt};

  // State update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recent_r <= 24'd0;
      phase_r  <= hrct_pkg::PH_LINE_START;
      idx_r    <= 4'd0;
      found_r  <= 1'b0;
      len_r    <= '0;
      hdr_r    <= 1'b0;
      hcnt_r   <= '0;
      bcnt_r   <= '0;
      ovf_r    <= 1'b0;
    end else if (take) begin
      recent_r <= recent_nxt;
      phase_r  <= phase_nxt;
      idx_r    <= idx_nxt;
      found_r  <= found_nxt;
      len_r    <= len_nxt;
      hdr_r    <= hdr_nxt;
      hcnt_r   <= hcnt_nxt;
      bcnt_r   <= bcnt_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

endmodule

FILE: src/http_request_completeness_tracker.sv
// HTTP request completeness tracker: one result word per request byte.
// The result for an accepted byte is registered into the output stage, or into the skid entry while the output is held.
// Throughput: one byte per cycle; the skid entry takes one more byte while a finished
// result waits for out_tready, and in_tready drops only while both entries are full.
// Reset (rst_n low, synchronous) clears all tracking state and empties the output stage.
module http_request_completeness_tracker #(
  parameter int LENGTH_BITS   = hrct_pkg::LENGTH_BITS_DEF,
  parameter int POSITION_BITS = hrct_pkg::POSITION_BITS_DEF,
  parameter int OUT_W         = ((2 * LENGTH_BITS + POSITION_BITS + 3 + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,   // data_byte
  input  logic             in_tuser,   // first_byte
  output logic             out_tvalid,
  input  logic             out_tready,
  // header_done, request_complete, expected_length, header_length,
  // body_bytes, length_overflow, zero fill
  output logic [OUT_W-1:0] out_tdata
);

  logic             take;
  logic [OUT_W-1:0] res_word;
  logic             out_valid_r;
  logic [OUT_W-1:0] out_data_r;
  logic             skid_valid_r;
  logic [OUT_W-1:0] skid_data_r;
  logic             out_free;

  assign in_tready = !skid_valid_r;
  assign take      = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  hrct_track #(
    .LENGTH_BITS   (LENGTH_BITS),
    .POSITION_BITS (POSITION_BITS),
    .RES_W         (OUT_W)
  ) u_track (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .data_byte  (in_tdata),
    .first_byte (in_tuser),
    .res_word   (res_word)
  );

  // Output register with skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (take) begin
      if (out_free) begin
        out_valid_r <= 1'b1;
        out_data_r  <= res_word;
      end else begin
        skid_valid_r <= 1'b1;
        skid_data_r  <= res_word;
      end
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        out_data_r   <= skid_data_r;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

FILE: verif/http_request_completeness_tracker_tb.sv
// Testbench for the HTTP request completeness tracker: byte streams in, checked status words out.
`timescale 1ns / 100ps

module http_request_completeness_tracker_tb;

  localparam int OUT_W = 72;
  localparam int HOLD_AT = 200;     // checked words before the long receiver hold-off
  localparam int HOLD_LEN = 400;    // cycles of that hold-off
  localparam int RANDOM_FILL = 600; // queued bytes before random requests stop

  // one request byte and its start-of-request flag
  typedef struct packed {
    logic [7:0] data;
    logic       first;
  } req_byte_t;

  // expected status after one byte
  typedef struct packed {
    logic        hdr_done;
    logic        complete;
    logic [23:0] clen;
    logic [15:0] hlen;
    logic [23:0] body;
    logic        ovf;
  } frame_status_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [7:0]       in_tdata = 8'h00;   // data_byte
  logic             in_tuser = 1'b0;    // first_byte
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  // header_done, request_complete, expected_length, header_length,
  // body_bytes, length_overflow, zero fill
  logic [OUT_W-1:0] out_tdata;

  req_byte_t     byte_q[$];
  frame_status_t status_q[$];
  logic [7:0]    req_bytes[$];   // scratch for the request being built
  string         field_name = "content-length:";

  // tracker state kept by the predictor
  logic [23:0]      recent;
  hrct_pkg::phase_t phase;
  logic [3:0]       match_idx;
  logic             len_found;
  logic [23:0]      len_val;
  logic             hdr_seen;
  logic [15:0]      hdr_cnt;
  logic [23:0]      body_cnt;
  logic             ovf;

  int errors = 0;
  int bytes_sent = 0;
  int results_checked = 0;
  int req_count = 0;
  int drv_gap = 0;
  int rx_stall = 0;
  int hold_count = 0;
  logic long_hold;

  http_request_completeness_tracker u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------
  task automatic clear_tracking();
    recent = '0;
    phase = hrct_pkg::PH_LINE_START;
    match_idx = '0;
    len_found = 1'b0;
    len_val = '0;
    hdr_seen = 1'b0;
    hdr_cnt = '0;
    body_cnt = '0;
    ovf = 1'b0;
  endtask

  function automatic logic [7:0] lower_ch(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
  endfunction

  // advance the tracker by one byte and queue the status it should report
  task automatic track_byte(input logic [7:0] c, input logic first);
    frame_status_t st;
    logic [31:0]   v;
    logic [3:0]    k;
    logic          digit;
    digit = (c >= hrct_pkg::CH_ZERO) && (c <= hrct_pkg::CH_NINE);
    if (first) clear_tracking();
    if (hdr_seen) begin
      if (body_cnt != '1) body_cnt++;
      else ovf = 1'b1;
    end else begin
      if (hdr_cnt != '1) hdr_cnt++;
      else ovf = 1'b1;
      if (phase == hrct_pkg::PH_LINE_START) begin
        // CR and LF at a line start are skipped
        if (c != hrct_pkg::CH_CR && c != hrct_pkg::CH_LF) begin
          if (!len_found && lower_ch(c) == field_name[0]) begin
            match_idx = 4'd1;
            phase = hrct_pkg::PH_MATCH;
          end else begin
            phase = hrct_pkg::PH_REST;
          end
        end
      end else if (c == hrct_pkg::CH_LF && recent[7:0] == hrct_pkg::CH_CR) begin
        phase = hrct_pkg::PH_LINE_START;
        match_idx = '0;
      end else if (phase == hrct_pkg::PH_MATCH) begin
        k = match_idx;
        if (k < hrct_pkg::NAME_LEN && lower_ch(c) == field_name[k]) begin
          k++;
          match_idx = k;
          if (k >= hrct_pkg::NAME_LEN) begin
            len_found = 1'b1;
            phase = hrct_pkg::PH_SPACES;
          end
        end else begin
          phase = hrct_pkg::PH_REST;
        end
      end else if (phase == hrct_pkg::PH_SPACES && c == hrct_pkg::CH_SPACE) begin
        // leading blanks before the digits
      end else if ((phase == hrct_pkg::PH_SPACES || phase == hrct_pkg::PH_DIGITS) && digit) begin
        v = len_val * 32'd10 + 32'(c - hrct_pkg::CH_ZERO);
        if (v > 32'h00FF_FFFF) begin
          v = 32'h00FF_FFFF;
          ovf = 1'b1;
        end
        len_val = v[23:0];
        phase = hrct_pkg::PH_DIGITS;
      end else begin
        phase = hrct_pkg::PH_REST;
      end
      if (recent == {hrct_pkg::CH_CR, hrct_pkg::CH_LF, hrct_pkg::CH_CR} &&
          c == hrct_pkg::CH_LF) hdr_seen = 1'b1;
    end
    recent = {recent[15:0], c};
    st.hdr_done = hdr_seen;
    st.complete = hdr_seen && (len_val == '0 || body_cnt >= len_val);
    st.clen = len_val;
    st.hlen = hdr_cnt;
    st.body = body_cnt;
    st.ovf = ovf;
    status_q.push_back(st);
  endtask

  // ---------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------
  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    errors++;
    if (errors <= 40)
      $display("MISMATCH t=%0t word %0d: %s got %0h expected %0h",
               $time, results_checked, what, got, want);
  endtask

  task automatic check_word(input logic [OUT_W-1:0] d);
    frame_status_t e;
    if (status_q.size() == 0) begin
      report("word with nothing expected", 32'(d[31:0]), 32'h0);
      return;
    end
    e = status_q.pop_front();
    if (d[0] !== e.hdr_done) report("header_done", 32'(d[0]), 32'(e.hdr_done));
    if (d[1] !== e.complete) report("request_complete", 32'(d[1]), 32'(e.complete));
    if (d[25:2] !== e.clen) report("expected_length", 32'(d[25:2]), 32'(e.clen));
    if (d[41:26] !== e.hlen) report("header_length", 32'(d[41:26]), 32'(e.hlen));
    if (d[65:42] !== e.body) report("body_bytes", 32'(d[65:42]), 32'(e.body));
    if (d[66] !== e.ovf) report("length_overflow", 32'(d[66]), 32'(e.ovf));
    if (d[71:67] !== '0) report("zero fill", 32'(d[71:67]), 32'h0);
  endtask

  // mostly no gap, sometimes short, rarely long
  function automatic int pick_gap(input bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 99) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------
  // Driver: one word per handshake from byte_q
  // ---------------------------------------------------------------
  always @(posedge clk) begin
    req_byte_t it;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      drv_gap = 0;
      clear_tracking();
    end else begin
      if (in_tvalid && in_tready) begin
        track_byte(in_tdata, in_tuser);
        bytes_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (drv_gap > 0 || byte_q.size() == 0) begin
          if (drv_gap > 0) drv_gap--;
          in_tvalid <= 1'b0;
        end else begin
          it = byte_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= it.data;
          in_tuser <= it.first;
          drv_gap = pick_gap(((bytes_sent / 128) % 4) == 3);
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // Monitor and receiver stalls
  // ---------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_stall = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        check_word(out_tdata);
        results_checked <= results_checked + 1;
      end
      if (long_hold) begin
        out_tready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        rx_stall = pick_gap(((results_checked / 150) % 4) == 2);
      end
    end
  end

  // one long hold-off so the output stage fills and backs up the input
  always @(posedge clk) begin
    if (!rst_n) hold_count <= 0;
    else if (long_hold) hold_count <= hold_count + 1;
  end
  assign long_hold = (results_checked >= HOLD_AT) && (hold_count < HOLD_LEN);

  // ---------------------------------------------------------------
  // Request builders
  // ---------------------------------------------------------------
  task automatic add_char(input logic [7:0] c);
    req_bytes.push_back(c);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
  endtask

  task automatic add_crlf();
    add_char(hrct_pkg::CH_CR);
    add_char(hrct_pkg::CH_LF);
  endtask

  // first n characters of the field name, letters in random case
  task automatic add_field_name(input int n);
    logic [7:0] ch;
    for (int i = 0; i < n; i++) begin
      ch = field_name[i];
      if (ch >= 8'h61 && ch <= 8'h7A && $urandom_range(0, 1)) ch = ch - 8'h20;
      add_char(ch);
    end
  endtask

  // move the built bytes to the send queue
  task automatic commit_bytes(input bit first);
    req_byte_t it;
    foreach (req_bytes[i]) begin
      it.data = req_bytes[i];
      it.first = first && (i == 0);
      byte_q.push_back(it);
    end
    req_bytes.delete();
    if (first) req_count++;
  endtask

  task automatic add_random_body(input int n);
    repeat (n) add_char(8'($urandom_range(0, 255)));
  endtask

  task automatic queue_random_request();
    int n_lines;
    int kind;
    int r;
    int clen;
    int body_n;
    bit have_len;
    bit big_len;
    have_len = 0;
    big_len = 0;
    clen = 0;
    add_text("GET /");
    repeat ($urandom_range(1, 6)) add_char(8'($urandom_range(97, 122)));
    add_text(" HTTP/1.1");
    add_crlf();
    n_lines = $urandom_range(0, 4);
    for (int l = 0; l < n_lines; l++) begin
      kind = $urandom_range(0, 9);
      if (kind <= 3 || kind == 9) begin
        // extra CR or LF at the line start on some lines
        if (kind == 9) add_char($urandom_range(0, 1) ? hrct_pkg::CH_CR : hrct_pkg::CH_LF);
        add_field_name(15);
        repeat ($urandom_range(0, 3)) add_char(hrct_pkg::CH_SPACE);
        r = $urandom_range(0, 19);
        if (r < 2) begin
          // name with no digits
        end else if (r < 4) begin
          add_text($sformatf("%0d", $urandom_range(16777216, 999999999)));
          if (!have_len) big_len = 1;
        end else begin
          if (r == 4) add_text("0");
          r = $urandom_range(0, 40);
          add_text($sformatf("%0d", r));
          if (!have_len) clen = r;
        end
        have_len = 1;
        if ($urandom_range(0, 4) == 0) add_text(" x");
      end else if (kind <= 5) begin
        add_text("Host: ");
        repeat ($urandom_range(1, 8)) add_char(8'($urandom_range(97, 122)));
      end else if (kind == 6) begin
        // name cut short by a wrong character
        add_field_name($urandom_range(1, 14));
        add_text("x: 7");
      end else if (kind == 7) begin
        add_text("A");
        add_char(hrct_pkg::CH_CR);
        add_text("B");
        add_char(hrct_pkg::CH_LF);
        add_text("C");
      end else begin
        add_random_body($urandom_range(1, 8));
      end
      add_crlf();
    end
    if ($urandom_range(0, 9) != 0) begin
      add_crlf();
      if (big_len) body_n = $urandom_range(0, 20);
      else if (clen > 0) body_n = clen + $urandom_range(0, 4) - 2;
      else body_n = $urandom_range(0, 5);
      if (body_n < 0) body_n = 0;
      add_random_body(body_n);
    end
    commit_bytes($urandom_range(0, 9) != 0);
  endtask

  // ---------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------
  initial begin
    // length line with mixed case, body a byte longer than the length
    add_text("CONTENT-length: 3");
    add_crlf();
    add_crlf();
    add_text("abcd");
    commit_bytes(1);
    // lone CR and LF inside a line, no length, extreme body bytes
    add_text("a");
    add_char(hrct_pkg::CH_CR);
    add_text("b");
    add_char(hrct_pkg::CH_LF);
    add_text("c");
    add_crlf();
    add_crlf();
    add_char(8'hFF);
    add_char(8'h00);
    commit_bytes(1);
    // matching line without digits, later length line ignored
    add_text("content-length:");
    add_crlf();
    add_text("Content-Length: 5");
    add_crlf();
    add_crlf();
    add_text("xy");
    commit_bytes(1);
    // too many digits
    add_text("Content-Length:  99999999");
    add_crlf();
    add_crlf();
    add_text("z");
    commit_bytes(1);

    // random requests with some noise in between
    while (byte_q.size() < RANDOM_FILL) begin
      if ($urandom_range(0, 7) == 0) begin
        add_random_body($urandom_range(1, 10));
        commit_bytes($urandom_range(0, 1) != 0);
      end
      queue_random_request();
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (byte_q.size() != 0 || in_tvalid || status_q.size() != 0);
    repeat (8) @(posedge clk);

    $display("Run covered %0d requests in %0d bytes: odd line breaks, length overflow, stalls.",
             req_count, bytes_sent);
    $display("%0d status words checked, %0d mismatches.", results_checked, errors);
    if (errors == 0 && status_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #40_000_000;
    $display("Watchdog expired: %0d words still expected", status_q.size());
    $display("Some tests failed");
    $finish;
  end

endmodule
